// ===== hw/rtl/rhfr_pkg.sv =====
// rhfr_pkg: shared constants and types for the resampled history fractional read block
// no dependencies; used by rhfr_slice and resampled_history_fractional_read
package rhfr_pkg;

   // default sizes of the history ring
   localparam int DEPTH_DEF       = 1024;
   localparam int FRAC_BITS_DEF   = 8;
   localparam int SAMPLE_BITS_DEF = 16;

   // fixed field widths
   localparam int TIME_W    = 20;
   localparam int EPS_W     = 10;
   localparam int AGO_W     = 18;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON       = 2'd1;

   // register reset values
   localparam logic [TIME_W-1:0] PERIOD_RESET  = 20'd16667;
   localparam logic [EPS_W-1:0]  EPSILON_RESET = 10'd100;

   // action codes
   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // sequencer commands to the time slicing unit
   typedef struct packed {
      logic load;
      logic slice;
      logic advance;
   } slice_ctrl_type;

   // status back from the time slicing unit
   typedef struct packed {
      logic more;
   } slice_stat_type;

endpackage

// ===== hw/rtl/rhfr_ram.sv =====
// rhfr_ram: generic single write, single read memory with registered read data
// no dependencies
module rhfr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rhfr_slice.sv =====
// rhfr_slice: time slicing unit, holds time to next slot, remaining delta and write pointer
// depends on rhfr_pkg
module rhfr_slice #(
   parameter int DEPTH = rhfr_pkg::DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rhfr_pkg::slice_ctrl_type     ctrl,
   input  logic [rhfr_pkg::TIME_W-1:0]  load_delta,
   input  logic [rhfr_pkg::TIME_W-1:0]  period,
   input  logic [rhfr_pkg::EPS_W-1:0]   epsilon,
   output logic [$clog2(DEPTH)-1:0]     wr_ptr,
   output logic [$clog2(DEPTH)-1:0]     slot_ptr,
   output rhfr_pkg::slice_stat_type     stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int TW = rhfr_pkg::TIME_W;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [TW-1:0] ttns_ff, ttns_in;
   logic [TW-1:0] delta_ff, delta_in;
   logic [AW-1:0] wp_ff, wp_in;

   logic [TW:0]   rem;
   logic [TW:0]   reload;
   logic [TW-1:0] period_eff;
   logic [TW-1:0] eps_ext;
   logic [AW-1:0] wp_inc;
   logic          adv;

   assign eps_ext    = TW'(epsilon);
   assign period_eff = (period == '0) ? TW'(1) : period;
   assign rem        = {1'b0, ttns_ff} - {1'b0, delta_ff};
   assign reload     = {1'b0, ttns_ff} + {1'b0, period_eff};
   assign adv        = (ttns_ff < eps_ext) || (ttns_ff == '0);
   assign wp_inc     = (wp_ff == LAST) ? '0 : wp_ff + AW'(1);

   always_comb begin
      ttns_in  = ttns_ff;
      delta_in = delta_ff;
      wp_in    = wp_ff;
      if (ctrl.load) begin
         delta_in = load_delta;
      end else if (ctrl.slice) begin
         // take the smaller of time left and delta off both
         if (rem[TW]) begin
            delta_in = delta_ff - ttns_ff;
            ttns_in  = '0;
         end else begin
            delta_in = '0;
            ttns_in  = rem[TW-1:0];
         end
      end else if (ctrl.advance && adv) begin
         wp_in   = wp_inc;
         ttns_in = reload[TW] ? '1 : reload[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttns_ff  <= rhfr_pkg::PERIOD_RESET;
         delta_ff <= '0;
         wp_ff    <= '0;
      end else begin
         ttns_ff  <= ttns_in;
         delta_ff <= delta_in;
         wp_ff    <= wp_in;
      end
   end

   assign wr_ptr    = wp_ff;
   assign slot_ptr  = adv ? wp_inc : wp_ff;
   assign stat.more = delta_ff > eps_ext;

endmodule

// ===== hw/rtl/resampled_history_fractional_read.sv =====
// resampled_history_fractional_read: history ring with slot timing and interpolated reads
// depends on rhfr_pkg, rhfr_ram and rhfr_slice
//
// channel   ports                          transfer when
// -------   -----------------------------  ---------------------------------
// request   start, busy, req_*             start high and busy low
// result    rsp_valid, rsp_history_value   rsp_valid high (one cycle, no stall)
// config    csr_wr_en, csr_index, csr_*    csr_wr_en high
//
// after reset the ring is cleared one entry a cycle, with busy high
// add: the item is taken in the idle state, then each time slice runs a subtract
//    state, then a slot advance and ring write state, on the slice unit; one slice per
//    slot crossed, plus one when the last slice ends short of a slot
// read: bound by two reads through the single ring read port and the multiply,
//    result strobed in the same cycle that busy drops
// the receiver cannot stall; one item is in flight at a time
module resampled_history_fractional_read #(
   parameter int DEPTH       = rhfr_pkg::DEPTH_DEF,
   parameter int FRAC_BITS   = rhfr_pkg::FRAC_BITS_DEF,
   parameter int SAMPLE_BITS = rhfr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_value,
   input  logic [rhfr_pkg::TIME_W-1:0]       req_delta_time,
   input  logic [rhfr_pkg::AGO_W-1:0]        req_samples_ago,
   // result channel
   output logic                              rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]     rsp_history_value,
   // configuration port
   input  logic                              csr_wr_en,
   input  logic [rhfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rhfr_pkg::CSR_DAT_W-1:0]    csr_wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int IW = AW + 1;
   localparam int SW = SAMPLE_BITS;
   localparam int CW = (rhfr_pkg::AGO_W > IW + FRAC_BITS) ? rhfr_pkg::AGO_W : IW + FRAC_BITS;
   localparam int PW = SW + FRAC_BITS + 2;
   localparam logic [CW-1:0] AGO_LIM = CW'(DEPTH - 1) << FRAC_BITS;
   localparam logic [IW-1:0] DEPTH_I = IW'(DEPTH);
   localparam logic [IW-1:0] BASE_OFS = IW'(DEPTH - 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLICE,
      ST_ADVANCE,
      ST_RD_POS,
      ST_RD_IDX,
      ST_RD_A,
      ST_RD_B,
      ST_RD_DIFF,
      ST_RD_MUL,
      ST_RD_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [rhfr_pkg::TIME_W-1:0] period_ff;
   logic [rhfr_pkg::EPS_W-1:0]  eps_ff;
   logic signed [SW-1:0]     sample_ff, sample_in;
   logic [CW-1:0]            ago_ff, ago_in;
   logic [CW-1:0]            pos_ff, pos_in;
   logic [AW-1:0]            i0_ff, i0_in;
   logic [AW-1:0]            i1_ff, i1_in;
   logic [FRAC_BITS-1:0]     frac_ff, frac_in;
   logic signed [SW-1:0]     a_ff, a_in;
   logic signed [SW:0]       diff_ff, diff_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]     rsp_value_ff, rsp_value_in;

   // ring port and slice unit hookup
   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr;
   logic [SW-1:0]            mem_wr_data;
   logic [AW-1:0]            mem_rd_addr;
   logic [SW-1:0]            mem_rd_data;
   rhfr_pkg::slice_ctrl_type slice_ctrl;
   rhfr_pkg::slice_stat_type slice_stat;
   logic [AW-1:0]            wr_ptr;
   logic [AW-1:0]            slot_ptr;

   // read datapath helpers
   logic                     accept;
   logic [CW-1:0]            ago_ext;
   logic [IW-1:0]            base;
   logic [IW-1:0]            idx_raw;
   logic [IW-1:0]            idx_wrap;
   logic signed [SW-1:0]     rd_sample;
   logic signed [PW-1:0]     rnd;
   logic signed [PW-1:0]     shifted;
   logic signed [PW-1:0]     interp;

   assign accept    = start && (state_ff == ST_IDLE);
   assign ago_ext   = CW'(req_samples_ago);
   assign base      = IW'(wr_ptr) + BASE_OFS;
   assign idx_raw   = pos_ff[FRAC_BITS +: IW];
   assign idx_wrap  = (idx_raw >= DEPTH_I) ? idx_raw - DEPTH_I : idx_raw;
   assign rd_sample = $signed(mem_rd_data);
   // arithmetic shift is floor division, so ties round up
   assign rnd       = prod_ff + $signed(HALF);
   assign shifted   = rnd >>> FRAC_BITS;
   assign interp    = shifted + PW'(a_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sample_in    = sample_ff;
      ago_in       = ago_ff;
      pos_in       = pos_ff;
      i0_in        = i0_ff;
      i1_in        = i1_ff;
      frac_in      = frac_ff;
      a_in         = a_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      slice_ctrl   = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = slot_ptr;
      mem_wr_data  = sample_ff;
      mem_rd_addr  = i0_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero the ring one entry a cycle
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_action == rhfr_pkg::ACT_ADD) begin
                  sample_in       = req_sample_value;
                  slice_ctrl.load = 1'b1;
                  // nothing to do when the delta is within tolerance
                  if (req_delta_time > rhfr_pkg::TIME_W'(eps_ff)) begin
                     state_in = ST_SLICE;
                  end
               end else begin
                  ago_in   = (ago_ext > AGO_LIM) ? AGO_LIM : ago_ext;
                  state_in = ST_RD_POS;
               end
            end
         end
         ST_SLICE: begin
            slice_ctrl.slice = 1'b1;
            state_in         = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            // advance the slot if due, then write the sample at the pointer
            slice_ctrl.advance = 1'b1;
            mem_wr_en          = 1'b1;
            state_in           = slice_stat.more ? ST_SLICE : ST_IDLE;
         end
         ST_RD_POS: begin
            pos_in   = (CW'(base) << FRAC_BITS) - ago_ff;
            state_in = ST_RD_IDX;
         end
         ST_RD_IDX: begin
            i0_in    = idx_wrap[AW-1:0];
            frac_in  = pos_ff[FRAC_BITS-1:0];
            state_in = ST_RD_A;
         end
         ST_RD_A: begin
            mem_rd_addr = i0_ff;
            i1_in       = (i0_ff == LAST) ? '0 : i0_ff + AW'(1);
            state_in    = ST_RD_B;
         end
         ST_RD_B: begin
            mem_rd_addr = i1_ff;
            a_in        = rd_sample;
            state_in    = ST_RD_DIFF;
         end
         ST_RD_DIFF: begin
            diff_in  = (SW + 1)'(rd_sample) - (SW + 1)'(a_ff);
            state_in = ST_RD_MUL;
         end
         ST_RD_MUL: begin
            prod_in  = diff_ff * $signed({1'b0, frac_ff});
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = interp[SW-1:0];
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= rhfr_pkg::PERIOD_RESET;
         eps_ff       <= rhfr_pkg::EPSILON_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               rhfr_pkg::CSR_SAMPLE_PERIOD: period_ff <= csr_wr_data[rhfr_pkg::TIME_W-1:0];
               rhfr_pkg::CSR_EPSILON:       eps_ff    <= csr_wr_data[rhfr_pkg::EPS_W-1:0];
               default: ;
            endcase
         end
      end
      // payload, no reset
      sample_ff    <= sample_in;
      ago_ff       <= ago_in;
      pos_ff       <= pos_in;
      i0_ff        <= i0_in;
      i1_ff        <= i1_in;
      frac_ff      <= frac_in;
      a_ff         <= a_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
   end

   rhfr_slice #(
      .DEPTH (DEPTH)
   ) u_slice (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (slice_ctrl),
      .load_delta (req_delta_time),
      .period     (period_ff),
      .epsilon    (eps_ff),
      .wr_ptr     (wr_ptr),
      .slot_ptr   (slot_ptr),
      .stat       (slice_stat)
   );

   rhfr_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_history_value = rsp_value_ff;

endmodule
